// ----- src/bst_pkg.sv -----
// Shared constants for the bounded set table: field widths, operation
// and status codes, default capacity. No dependencies.
package bst_pkg;

  localparam int KEY_W            = 32;
  localparam int OP_W             = 2;
  localparam int COUNT_OUT_W      = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ----- src/bst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/bounded_set_table.sv -----
// Bounded set table top level: scan sequencer around one key comparator.
// Depends on bst_pkg and bst_ram.
//
//   channel   handshake        payload
//   input     start / busy     in_operation, in_key
//   result    out_valid        out_was_present, out_status, out_count
//
// An item is taken when start is high and busy is low. busy then stays high
// while the single RAM read port walks the held keys through one comparator.
// The result strobes in the first cycle with busy low, and the next item can
// be taken in that cycle. Remove compacts in the same pass through the RAM
// write port. Reset is synchronous and empties the set at once. The receiver
// cannot stall; each result shows for one cycle.
module bounded_set_table
  import bst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        in_operation,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                   out_valid,
  output logic                   out_was_present,
  output logic                   out_status,
  output logic [COUNT_OUT_W-1:0] out_count
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_r, state_nxt;
  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic             pend_r, pend_nxt;
  logic             match_r, match_nxt;

  logic             valid_r, valid_nxt;
  logic             present_r, present_nxt;
  logic             status_r, status_nxt;
  logic [CNT_W-1:0] res_count_r, res_count_nxt;

  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [KEY_W-1:0] rd_data;
  logic             hit;

  bst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY),
    .ADDR_W(AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_idx_r[AW-1:0]),
    .rd_data(rd_data)
  );

  // the one comparator, fed by the RAM read data
  assign hit = (rd_data == key_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    kept_nxt      = kept_r;
    pend_nxt      = pend_r;
    match_nxt     = match_r;
    valid_nxt     = 1'b0;
    present_nxt   = present_r;
    status_nxt    = status_r;
    res_count_nxt = res_count_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = kept_r[AW-1:0];
    wr_data       = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_SCAN;
          rd_idx_nxt = '0;
          kept_nxt   = '0;
          pend_nxt   = 1'b0;
          match_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (hit) begin
            match_nxt = 1'b1;
          end else if (op_r == OP_REMOVE) begin
            // shift the survivor down to the next kept slot
            wr_en    = 1'b1;
            kept_nxt = kept_r + 1'b1;
          end
        end
        if (rd_idx_r < count_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!pend_r && rd_idx_r == count_r) begin
          state_nxt   = ST_IDLE;
          valid_nxt   = 1'b1;
          present_nxt = match_r;
          status_nxt  = STATUS_DONE;
          if (op_r == OP_ADD) begin
            if (!match_r) begin
              if (count_r < CNT_W'(CAPACITY)) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = key_r;
                count_nxt = count_r + 1'b1;
              end else begin
                status_nxt = STATUS_FULL;
              end
            end
          end else if (op_r == OP_REMOVE) begin
            count_nxt = kept_r;
          end
          res_count_nxt = count_nxt;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      valid_r  <= 1'b0;
      pend_r   <= 1'b0;
      match_r  <= 1'b0;
      rd_idx_r <= '0;
      kept_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      pend_r   <= pend_nxt;
      match_r  <= match_nxt;
      rd_idx_r <= rd_idx_nxt;
      kept_r   <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    present_r   <= present_nxt;
    status_r    <= status_nxt;
    res_count_r <= res_count_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = valid_r;
  assign out_was_present = present_r;
  assign out_status      = status_r;
  assign out_count       = COUNT_OUT_W'(res_count_r);

endmodule

// ----- src/bst_checker.sv -----
// Port-level checks for bounded_set_table, bound to the top level.
// Depends on bst_pkg.
module bst_checker
  import bst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic                   out_was_present,
  input logic                   out_status,
  input logic [COUNT_OUT_W-1:0] out_count
);

  // a taken item always raises busy from the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the result strobes only once the scan has ended
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // busy drops only when a result is delivered
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  // a dropped add means the key was absent and the set is full
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |->
      (!out_was_present && out_count == COUNT_OUT_W'(CAPACITY)))
    else $error("full status with inconsistent result");

endmodule

bind bounded_set_table bst_checker #(.CAPACITY(CAPACITY)) u_bst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_was_present(out_was_present),
  .out_status     (out_status),
  .out_count      (out_count)
);
